/* src/uart_ring_buffer_controller_defines.svh */
// Assertion macros shared by the buffered UART controller RTL.
`ifndef UART_RING_BUFFER_CONTROLLER_DEFINES_SVH
`define UART_RING_BUFFER_CONTROLLER_DEFINES_SVH

// Concurrent property on the current cycle, sampled on clk and masked in reset.
`define URBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property that must hold in the cycle after the trigger.
`define URBC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* src/urbc_pkg.sv */
// Types, constants and helper functions of the buffered UART controller.
`default_nettype none

package urbc_pkg;

	localparam int RX_DEPTH = 256;
	localparam int TX_DEPTH = 256;
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);

	localparam int LEVEL_W = 9;
	localparam int BYTE_W = 8;
	localparam int FLAG_W = 5;
	localparam int ERR_W = 2;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
	localparam logic [LEVEL_W-1:0] RX_CAP_MAX =
		(RX_DEPTH > int'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(RX_DEPTH);
	localparam logic [LEVEL_W-1:0] TX_CAP_MAX =
		(TX_DEPTH > int'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(TX_DEPTH);

	localparam int ADDR_W = 5;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam int DATA_W = 32;

	localparam logic [REG_IDX_W-1:0] REG_RX_CAP = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TX_CAP = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RX_EN = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PARITY_EN = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ERROR_EN = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_EN = 3'd5;

	localparam logic [1:0] OP_TX_BYTE = 2'd0;
	localparam logic [1:0] OP_RX_READ = 2'd1;
	localparam logic [1:0] OP_EVENT = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TX_FULL = 2'd1;
	localparam logic [1:0] ST_NO_DATA = 2'd2;

	localparam int FLAG_PARITY = 0;
	localparam int FLAG_FRAME = 1;
	localparam int FLAG_OVERRUN = 2;
	localparam int FLAG_NOISE = 3;
	localparam int FLAG_TIMEOUT = 4;

	localparam int ERR_HW = 0;
	localparam int ERR_RX_FULL = 1;

	typedef struct packed {
		logic [1:0] op;
		logic [BYTE_W-1:0] data_byte;
		logic first_of_message;
		logic [LEVEL_W-1:0] msg_len;
		logic rx_ready;
		logic tx_empty;
		logic [FLAG_W-1:0] error_flags;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [BYTE_W-1:0] rx_byte;
		logic tx_byte_valid;
		logic [BYTE_W-1:0] tx_byte;
		logic data_ready;
		logic [FLAG_W-1:0] clear_mask;
		logic [ERR_W-1:0] error_bits;
		logic tx_irq_enabled;
		logic [LEVEL_W-1:0] rx_level;
		logic [LEVEL_W-1:0] tx_level;
	} rsp_t;

	// A capacity of zero behaves as one, and one above the ring size as the ring size.
	function automatic logic [LEVEL_W-1:0] eff_cap(input logic [LEVEL_W-1:0] cap,
			input logic [LEVEL_W-1:0] cap_max);
		if (cap == '0) begin
			return LEVEL_W'(1);
		end else if (cap > cap_max) begin
			return cap_max;
		end
		return cap;
	endfunction

	// Pointer wraps to zero once the next index reaches the capacity.
	function automatic logic [LEVEL_W-1:0] ring_next(input logic [LEVEL_W-1:0] ptr,
			input logic [LEVEL_W-1:0] cap);
		logic [LEVEL_W-1:0] n;
		n = ptr + LEVEL_W'(1);
		return (n >= cap) ? '0 : n;
	endfunction

endpackage

`default_nettype wire

/* src/urbc_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module urbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/uart_ring_buffer_controller.sv */
// Buffered UART controller top level: transmit and receive rings with an APB register port.
// Words arrive on req (req_valid, req_stall) and each produces one word on rsp
// (rsp_valid, rsp_stall); a word moves at a rising edge with valid high and stall low.
// A req word is an op: push a transmit message byte, pop the receive ring, or apply a
// UART event (store a received byte, drain a transmit byte, or report error flags).
// The accepting edge updates the pointers and issues the ring memory access; the
// response register is loaded with the read data once it is free to take the word.
// Throughput is one word per cycle while rsp_stall is low; each word makes at most
// one access to each ring memory, which has one write and one registered read port.
// When rsp_stall is high the response register holds its word, one more word waits
// in the memory stage, and req_stall then rises until the response is taken.
// Reset empties both rings, sets both capacities to 256, enables reception
// and clears the sticky errors; the ring memories are not cleared and no
// clearing pass is needed, since an entry is only read after it was written.
// Registers are written over APB at byte address 4*i, by the user only while the block is
// idle, a rule left to the user; pready is always high and reads return the register value.
`default_nettype none
`include "uart_ring_buffer_controller_defines.svh"

module uart_ring_buffer_controller (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire urbc_pkg::req_t req,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output urbc_pkg::rsp_t rsp,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [urbc_pkg::ADDR_W-1:0] paddr,
	input wire logic [urbc_pkg::DATA_W-1:0] pwdata,
	output logic [urbc_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	logic [urbc_pkg::LEVEL_W-1:0] rx_cap_q, tx_cap_q;
	logic rx_en_q, parity_en_q, error_en_q, timeout_en_q;

	logic [urbc_pkg::RX_AW-1:0] rx_head_q, rx_tail_q;
	logic [urbc_pkg::TX_AW-1:0] tx_head_q, tx_tail_q;
	logic [urbc_pkg::LEVEL_W-1:0] rx_count_q, tx_count_q;
	logic [urbc_pkg::ERR_W-1:0] err_q;
	logic tx_irq_q, msg_acc_q;

	logic s1_valid_s1, rd_rx_s1, drain_s1, ready_s1;
	logic [1:0] status_s1;
	logic [urbc_pkg::FLAG_W-1:0] clear_s1;

	logic rsp_valid_q;
	urbc_pkg::rsp_t rsp_q;

	logic accept, load, cfg_wr;
	logic [urbc_pkg::REG_IDX_W-1:0] reg_idx;
	logic [urbc_pkg::LEVEL_W-1:0] rcap, tcap;
	logic msg_fits, tx_push, rx_pop, rx_take, rx_push, rx_ovf, drain, irq_off, hw_err, ready;
	logic [1:0] status;
	logic [urbc_pkg::FLAG_W-1:0] clear;
	logic [urbc_pkg::FLAG_W-1:0] flags;
	logic [urbc_pkg::LEVEL_W-1:0] rx_head_nx, rx_tail_nx, tx_head_nx, tx_tail_nx;
	logic [urbc_pkg::BYTE_W-1:0] rx_rdata, tx_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign reg_idx = paddr[urbc_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_cap_q <= urbc_pkg::LEVEL_W'(256);
			tx_cap_q <= urbc_pkg::LEVEL_W'(256);
			rx_en_q <= 1'b1;
			parity_en_q <= 1'b0;
			error_en_q <= 1'b0;
			timeout_en_q <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				urbc_pkg::REG_RX_CAP: rx_cap_q <= pwdata[urbc_pkg::LEVEL_W-1:0];
				urbc_pkg::REG_TX_CAP: tx_cap_q <= pwdata[urbc_pkg::LEVEL_W-1:0];
				urbc_pkg::REG_RX_EN: rx_en_q <= pwdata[0];
				urbc_pkg::REG_PARITY_EN: parity_en_q <= pwdata[0];
				urbc_pkg::REG_ERROR_EN: error_en_q <= pwdata[0];
				urbc_pkg::REG_TIMEOUT_EN: timeout_en_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			urbc_pkg::REG_RX_CAP: prdata = urbc_pkg::DATA_W'(rx_cap_q);
			urbc_pkg::REG_TX_CAP: prdata = urbc_pkg::DATA_W'(tx_cap_q);
			urbc_pkg::REG_RX_EN: prdata = urbc_pkg::DATA_W'(rx_en_q);
			urbc_pkg::REG_PARITY_EN: prdata = urbc_pkg::DATA_W'(parity_en_q);
			urbc_pkg::REG_ERROR_EN: prdata = urbc_pkg::DATA_W'(error_en_q);
			urbc_pkg::REG_TIMEOUT_EN: prdata = urbc_pkg::DATA_W'(timeout_en_q);
			default: prdata = '0;
		endcase
	end

	assign load = s1_valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = s1_valid_s1 && !load;
	assign accept = req_valid && !req_stall;

	assign rcap = urbc_pkg::eff_cap(rx_cap_q, urbc_pkg::RX_CAP_MAX);
	assign tcap = urbc_pkg::eff_cap(tx_cap_q, urbc_pkg::TX_CAP_MAX);
	assign flags = req.error_flags;
	assign msg_fits = ({1'b0, tx_count_q} + {1'b0, req.msg_len}) <= {1'b0, tcap};

	always_comb begin
		tx_push = 1'b0;
		rx_pop = 1'b0;
		rx_take = 1'b0;
		rx_push = 1'b0;
		rx_ovf = 1'b0;
		drain = 1'b0;
		irq_off = 1'b0;
		hw_err = 1'b0;
		ready = 1'b0;
		status = urbc_pkg::ST_OK;
		clear = '0;
		case (req.op)
			urbc_pkg::OP_TX_BYTE: begin
				tx_push = (req.first_of_message ? msg_fits : msg_acc_q) && (tx_count_q < tcap);
				status = tx_push ? urbc_pkg::ST_OK : urbc_pkg::ST_TX_FULL;
			end
			urbc_pkg::OP_RX_READ: begin
				rx_pop = rx_count_q != '0;
				status = rx_pop ? urbc_pkg::ST_OK : urbc_pkg::ST_NO_DATA;
			end
			urbc_pkg::OP_EVENT: begin
				if (flags == '0) begin
					rx_take = req.rx_ready && rx_en_q;
					rx_push = rx_take && (rx_count_q < rcap);
					rx_ovf = rx_take && !rx_push;
					ready = rx_take && (rx_push || (rx_count_q != '0));
					drain = req.tx_empty && tx_irq_q && (tx_count_q != '0);
					irq_off = req.tx_empty && tx_irq_q && (tx_count_q == '0);
				end else begin
					hw_err = 1'b1;
					clear[urbc_pkg::FLAG_PARITY] = flags[urbc_pkg::FLAG_PARITY] && parity_en_q;
					clear[urbc_pkg::FLAG_FRAME] = flags[urbc_pkg::FLAG_FRAME];
					clear[urbc_pkg::FLAG_OVERRUN] = flags[urbc_pkg::FLAG_OVERRUN]
						&& (rx_en_q || error_en_q);
					clear[urbc_pkg::FLAG_NOISE] = flags[urbc_pkg::FLAG_NOISE] && error_en_q;
					clear[urbc_pkg::FLAG_TIMEOUT] = flags[urbc_pkg::FLAG_TIMEOUT] && timeout_en_q;
				end
			end
			default: ;
		endcase
	end

	assign rx_head_nx = urbc_pkg::ring_next(urbc_pkg::LEVEL_W'(rx_head_q), rcap);
	assign rx_tail_nx = urbc_pkg::ring_next(urbc_pkg::LEVEL_W'(rx_tail_q), rcap);
	assign tx_head_nx = urbc_pkg::ring_next(urbc_pkg::LEVEL_W'(tx_head_q), tcap);
	assign tx_tail_nx = urbc_pkg::ring_next(urbc_pkg::LEVEL_W'(tx_tail_q), tcap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q <= '0;
			rx_tail_q <= '0;
			rx_count_q <= '0;
			tx_head_q <= '0;
			tx_tail_q <= '0;
			tx_count_q <= '0;
			err_q <= '0;
			tx_irq_q <= 1'b0;
			msg_acc_q <= 1'b0;
		end else if (accept) begin
			if (req.op == urbc_pkg::OP_TX_BYTE && req.first_of_message) begin
				msg_acc_q <= msg_fits;
			end
			if (tx_push) begin
				tx_tail_q <= tx_tail_nx[urbc_pkg::TX_AW-1:0];
				tx_count_q <= tx_count_q + urbc_pkg::LEVEL_W'(1);
				tx_irq_q <= 1'b1;
			end else if (drain) begin
				tx_head_q <= tx_head_nx[urbc_pkg::TX_AW-1:0];
				tx_count_q <= tx_count_q - urbc_pkg::LEVEL_W'(1);
			end else if (irq_off) begin
				tx_irq_q <= 1'b0;
			end
			if (rx_push) begin
				rx_tail_q <= rx_tail_nx[urbc_pkg::RX_AW-1:0];
				rx_count_q <= rx_count_q + urbc_pkg::LEVEL_W'(1);
			end else if (rx_pop) begin
				rx_head_q <= rx_head_nx[urbc_pkg::RX_AW-1:0];
				rx_count_q <= rx_count_q - urbc_pkg::LEVEL_W'(1);
			end
			if (hw_err) begin
				err_q[urbc_pkg::ERR_HW] <= 1'b1;
			end
			if (rx_ovf) begin
				err_q[urbc_pkg::ERR_RX_FULL] <= 1'b1;
			end
		end
	end

	urbc_ram #(
		.WIDTH(urbc_pkg::BYTE_W),
		.DEPTH(urbc_pkg::RX_DEPTH)
	) u_rx_ram (
		.clk(clk),
		.we(accept && rx_push),
		.waddr(rx_tail_q),
		.wdata(req.data_byte),
		.re(accept && rx_pop),
		.raddr(rx_head_q),
		.rdata(rx_rdata)
	);

	urbc_ram #(
		.WIDTH(urbc_pkg::BYTE_W),
		.DEPTH(urbc_pkg::TX_DEPTH)
	) u_tx_ram (
		.clk(clk),
		.we(accept && tx_push),
		.waddr(tx_tail_q),
		.wdata(req.data_byte),
		.re(accept && drain),
		.raddr(tx_head_q),
		.rdata(tx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else begin
			s1_valid_s1 <= accept || (s1_valid_s1 && !load);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
			rd_rx_s1 <= rx_pop;
			drain_s1 <= drain;
			ready_s1 <= ready;
			clear_s1 <= clear;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// The ring state registers already hold the values left by the word in the memory stage.
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.status <= status_s1;
			rsp_q.rx_byte <= rd_rx_s1 ? rx_rdata : '0;
			rsp_q.tx_byte_valid <= drain_s1;
			rsp_q.tx_byte <= drain_s1 ? tx_rdata : '0;
			rsp_q.data_ready <= ready_s1;
			rsp_q.clear_mask <= clear_s1;
			rsp_q.error_bits <= err_q;
			rsp_q.tx_irq_enabled <= tx_irq_q;
			rsp_q.rx_level <= rx_count_q;
			rsp_q.tx_level <= tx_count_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	`URBC_ASSERT(a_rx_count_max, rx_count_q <= urbc_pkg::RX_CAP_MAX, "receive level above ring size")
	`URBC_ASSERT(a_tx_irq_with_data, (tx_count_q == '0) || tx_irq_q, "transmit data held with interrupt off")
	`URBC_ASSERT_NEXT(a_state_on_accept, !accept, $stable(rx_count_q) && $stable(tx_count_q), "ring level changed without a word")
	`URBC_ASSERT_NEXT(a_s1_held, s1_valid_s1 && rsp_valid_q && rsp_stall, s1_valid_s1, "word in memory stage lost under stall")

endmodule

`default_nettype wire
